[design/hf_pkg.sv]
// Shared types and constants for the node-table Huffman decoder.
package hf_pkg;

  localparam int CODE_W      = 32;
  localparam int CODE_IDX_W  = 5;
  localparam int LEN_W       = 6;
  localparam int SYM_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int PAYLOAD_W   = 24;
  // Longest code that a load walks; longer lengths saturate to this.
  localparam int MAX_CODE_LEN = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  kind;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [BYTE_W-1:0] data;
  } hf_cmd_t;

endpackage

[design/hf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hf_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/hf_front.sv]
// Front end: accept input beats, classify commands, queue them for the walker.
module hf_front
  import hf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [55:0]         in_tdata,
  input  logic [CMD_W-1:0]    in_tuser,
  output logic                cmd_valid,
  output hf_cmd_t             cmd,
  input  logic                cmd_pop
);

  hf_cmd_t    q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  hf_cmd_t    in_cmd;
  logic [LEN_W-1:0] raw_len;
  logic       keep;
  logic       push;
  logic       pop;

  assign raw_len = in_tdata[CODE_W +: LEN_W];

  // Saturate the code length and drop loads that carry no code.
  always_comb begin
    in_cmd.kind = in_tuser;
    in_cmd.bits = in_tdata[CODE_W-1:0];
    in_cmd.len  = (raw_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : raw_len;
    in_cmd.sym  = in_tdata[CODE_W+LEN_W +: SYM_W];
    in_cmd.data = in_tdata[CODE_W+LEN_W+SYM_W +: BYTE_W];
    keep        = !((in_tuser == CMD_LOAD) && (raw_len == '0));
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = cmd_pop && (cnt_r != 2'd0);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

[design/hf_back.sv]
// Back end: node table walker for code loads and byte decodes, plus result register.
module hf_back
  import hf_pkg::*;
#(
  parameter int NODE_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  hf_cmd_t              cmd,
  output logic                 cmd_pop,
  input  logic [PAYLOAD_W-1:0] payload_length,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SYM_W-1:0]     out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  localparam int AW      = $clog2(NODE_DEPTH);
  localparam int NW      = $clog2(NODE_DEPTH + 1);
  localparam int EW      = 1 + SYM_W + 2 * AW;
  localparam int E_LEAF  = 0;
  localparam int E_SYM   = 1;
  localparam int E_K0    = 1 + SYM_W;
  localparam int E_K1    = E_K0 + AW;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_L_ROOT  = 4'd2;
  localparam logic [3:0] S_L_STEP  = 4'd3;
  localparam logic [3:0] S_L_NEW   = 4'd4;
  localparam logic [3:0] S_L_MOD   = 4'd5;
  localparam logic [3:0] S_D_NODE  = 4'd6;
  localparam logic [3:0] S_D_CHILD = 4'd7;
  localparam logic [3:0] S_D_FLUSH = 4'd8;

  logic [3:0]           state_r, state_nxt;
  hf_cmd_t              cmd_r, cmd_nxt;
  logic [EW-1:0]        cur_r, cur_nxt;
  logic [AW-1:0]        node_r, node_nxt;
  logic [LEN_W-1:0]     i_r, i_nxt;
  logic [NW-1:0]        nu_r, nu_nxt;
  logic [AW-1:0]        walk_r, walk_nxt;
  logic [PAYLOAD_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]           bit_r, bit_nxt;
  logic [AW-1:0]        kid_r, kid_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]     pend_sym_r, pend_sym_nxt;
  logic                 pend_bad_r, pend_bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]     out_sym_r, out_sym_nxt;
  logic                 out_bad_r, out_bad_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;

  logic                 out_free;
  logic                 load_bit;
  logic                 load_last;
  logic [AW-1:0]        load_kid;
  logic                 dec_bit;
  logic [AW-1:0]        dec_kid;
  logic                 emit_ok;
  logic                 table_full;
  logic [EW-1:0]        fresh;
  logic [EW-1:0]        linked;
  logic [EW-1:0]        marked;

  hf_ram #(.WIDTH(EW), .DEPTH(NODE_DEPTH)) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free   = !out_valid_r || out_tready;
  assign load_bit   = (i_r < LEN_W'(CODE_W)) ? cmd_r.bits[i_r[CODE_IDX_W-1:0]] : 1'b0;
  assign load_last  = ({1'b0, i_r} + 7'd1) == {1'b0, cmd_r.len};
  assign load_kid   = load_bit ? cur_r[E_K1 +: AW] : cur_r[E_K0 +: AW];
  assign dec_bit    = cmd_r.data[bit_r];
  assign dec_kid    = dec_bit ? rd_data[E_K1 +: AW] : rd_data[E_K0 +: AW];
  assign emit_ok    = cnt_r < payload_length;
  assign table_full = (nu_r == NW'(NODE_DEPTH));

  // Entry images used by the load walk.
  always_comb begin
    fresh = '0;
    fresh[E_LEAF] = load_last;
    if (load_last) begin
      fresh[E_SYM +: SYM_W] = cmd_r.sym;
    end
    linked = cur_r;
    if (load_bit) begin
      linked[E_K1 +: AW] = nu_r[AW-1:0];
    end else begin
      linked[E_K0 +: AW] = nu_r[AW-1:0];
    end
    marked = rd_data;
    marked[E_LEAF] = load_last;
    if (load_last) begin
      marked[E_SYM +: SYM_W] = cmd_r.sym;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    node_nxt       = node_r;
    i_nxt          = i_r;
    nu_nxt         = nu_r;
    walk_nxt       = walk_r;
    cnt_nxt        = cnt_r;
    bit_nxt        = bit_r;
    kid_nxt        = kid_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_bad_nxt   = pend_bad_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_sym_nxt    = out_sym_r;
    out_bad_nxt    = out_bad_r;
    out_last_nxt   = out_last_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      S_INIT: begin
        // Write an empty root once after reset.
        wr_en     = 1'b1;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          i_nxt   = '0;
          bit_nxt = '0;
          case (cmd.kind)
            CMD_CLEAR: begin
              wr_en    = 1'b1;
              nu_nxt   = NW'(1);
              walk_nxt = '0;
            end
            CMD_LOAD: begin
              rd_en     = 1'b1;
              state_nxt = S_L_ROOT;
            end
            CMD_DECODE: begin
              rd_en     = 1'b1;
              rd_addr   = walk_r;
              state_nxt = S_D_NODE;
            end
            CMD_START: begin
              walk_nxt = '0;
              cnt_nxt  = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_L_ROOT: begin
        cur_nxt   = rd_data;
        node_nxt  = '0;
        state_nxt = S_L_STEP;
      end

      S_L_STEP: begin
        if (load_kid != '0) begin
          rd_en     = 1'b1;
          rd_addr   = load_kid;
          node_nxt  = load_kid;
          state_nxt = S_L_MOD;
        end else if (table_full) begin
          // Abandon the rest of the load; placed nodes stay.
          state_nxt = S_IDLE;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = node_r;
          wr_data   = linked;
          node_nxt  = nu_r[AW-1:0];
          nu_nxt    = nu_r + NW'(1);
          cur_nxt   = fresh;
          state_nxt = S_L_NEW;
        end
      end

      S_L_NEW: begin
        wr_en     = 1'b1;
        wr_addr   = node_r;
        wr_data   = cur_r;
        i_nxt     = i_r + LEN_W'(1);
        state_nxt = load_last ? S_IDLE : S_L_STEP;
      end

      S_L_MOD: begin
        wr_en     = 1'b1;
        wr_addr   = node_r;
        wr_data   = marked;
        cur_nxt   = marked;
        i_nxt     = i_r + LEN_W'(1);
        state_nxt = load_last ? S_IDLE : S_L_STEP;
      end

      S_D_NODE: begin
        // rd_data holds the entry at the walk position.
        if (dec_kid == '0) begin
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = pend_sym_r;
              out_bad_nxt   = pend_bad_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = '0;
            pend_bad_nxt   = 1'b1;
            walk_nxt       = '0;
            bit_nxt        = bit_r + 3'd1;
            if (&bit_r) begin
              state_nxt = S_D_FLUSH;
            end else begin
              rd_en = 1'b1;
            end
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = dec_kid;
          kid_nxt   = dec_kid;
          state_nxt = S_D_CHILD;
        end
      end

      S_D_CHILD: begin
        if (rd_data[E_LEAF]) begin
          if (!(emit_ok && pend_valid_r && !out_free)) begin
            if (emit_ok) begin
              if (pend_valid_r) begin
                out_valid_nxt = 1'b1;
                out_sym_nxt   = pend_sym_r;
                out_bad_nxt   = pend_bad_r;
                out_last_nxt  = 1'b0;
              end
              pend_valid_nxt = 1'b1;
              pend_sym_nxt   = rd_data[E_SYM +: SYM_W];
              pend_bad_nxt   = 1'b0;
              cnt_nxt        = cnt_r + PAYLOAD_W'(1);
            end
            walk_nxt = '0;
            bit_nxt  = bit_r + 3'd1;
            if (&bit_r) begin
              state_nxt = S_D_FLUSH;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_D_NODE;
            end
          end
        end else begin
          // Inner node: hold rd_data, it is the next bit's entry.
          walk_nxt  = kid_r;
          bit_nxt   = bit_r + 3'd1;
          state_nxt = (&bit_r) ? S_D_FLUSH : S_D_NODE;
        end
      end

      S_D_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sym_nxt    = pend_sym_r;
          out_bad_nxt    = pend_bad_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      nu_r         <= NW'(1);
      walk_r       <= '0;
      cnt_r        <= '0;
      i_r          <= '0;
      bit_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nu_r         <= nu_nxt;
      walk_r       <= walk_nxt;
      cnt_r        <= cnt_nxt;
      i_r          <= i_nxt;
      bit_r        <= bit_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_r      <= cur_nxt;
    node_r     <= node_nxt;
    kid_r      <= kid_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_bad_r <= pend_bad_nxt;
    out_sym_r  <= out_sym_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_bad_r;
  assign out_tlast  = out_last_r;

  a_reset_init: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_INIT))
    else $error("walker did not restart with root write");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("result left pending after item finished");

  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nu_r != '0) && (nu_r <= NW'(NODE_DEPTH)))
    else $error("node count out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == S_IDLE) && cmd_valid)
    else $error("command taken while walker busy");

endmodule

[design/huffman_tree_decoder_top.sv]
// Top level of the node-table Huffman decoder: config register, front end, walker.
// Decode: a beat is taken from the queue, then each of the eight cipher bits is walked
//   in S_D_NODE, plus S_D_CHILD on an existing child, over the single node RAM read
//   port; S_D_FLUSH hands over the final result. A full output stalls the walk.
// Load: fetch the root, then one node per code bit. Clear and start finish in S_IDLE.
// Reset (rst_n low, synchronous) empties the tree and counters; the cycle after reset
//   writes the empty root, and inputs are queued meanwhile.
module huffman_tree_decoder_top
  import hf_pkg::*;
#(
  parameter int NODE_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // code_bits[31:0], code_length[37:32], code_symbol[45:38], data_byte[53:46], zero pad
  input  logic [55:0]          in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]     in_tuser,
  // Result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // symbol[7:0]
  output logic [SYM_W-1:0]     out_tdata,
  // bad_path[0]
  output logic                 out_tuser,
  output logic                 out_tlast,
  // Configuration: payload_length
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PAYLOAD_W-1:0] cfg_data
);

  logic [PAYLOAD_W-1:0] payload_length_r;
  logic                 cmd_valid;
  hf_cmd_t              cmd;
  logic                 cmd_pop;

  // Config writes must land only while idle; unenforced, they are taken every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_length_r <= '0;
    end else if (cfg_valid) begin
      payload_length_r <= cfg_data;
    end
  end

  // Front: classify and queue beats so the input side keeps moving during a walk.
  hf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: walk the node table and drive the result register.
  hf_back #(.NODE_DEPTH(NODE_DEPTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .payload_length (payload_length_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

endmodule

[tb/sv/huffman_decode_checker.sv]
// Checker for the Huffman tree decoder: mirrors the node table, predicts results, compares beats.
module huffman_decode_checker
  import hf_pkg::*;
#(
  parameter int NODE_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [55:0]          in_tdata,
  input  logic [CMD_W-1:0]     in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [SYM_W-1:0]     out_tdata,
  input  logic                 out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [PAYLOAD_W-1:0] cfg_data,
  output int                   pending,
  output int                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_LO  = CODE_W;
  localparam int SYM_LO  = LEN_LO + LEN_W;
  localparam int DATA_LO = SYM_LO + SYM_W;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             bad_path;
    logic             last;
  } decoded_t;

  logic                 node_leaf [NODE_DEPTH];
  logic [SYM_W-1:0]     node_sym  [NODE_DEPTH];
  int                   node_kid  [NODE_DEPTH][2];
  int                   nodes_used;
  int                   walk_node;
  logic [PAYLOAD_W-1:0] symbols_out;
  logic [PAYLOAD_W-1:0] payload_len;
  decoded_t             expected_symbols [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wipe_node(input int idx);
    node_leaf[idx]   = 1'b0;
    node_sym[idx]    = '0;
    node_kid[idx][0] = 0;
    node_kid[idx][1] = 0;
  endtask

  // Insert one code, bit 0 first; stop placing nodes once the table is full.
  task automatic grow_code_path(input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len,
                                input logic [SYM_W-1:0] sym);
    int   node;
    int   next;
    int   steps;
    logic full;
    node  = 0;
    full  = 1'b0;
    steps = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
    for (int i = 0; i < steps && !full; i++) begin
      next = node_kid[node][bits[i]];
      if (next == 0 || next >= NODE_DEPTH) begin
        if (nodes_used >= NODE_DEPTH) begin
          full = 1'b1;
        end else begin
          next = nodes_used;
          nodes_used++;
          wipe_node(next);
          node_kid[node][bits[i]] = next;
        end
      end
      if (!full) begin
        // last load wins: a leaf may turn inner and back, children stay
        node_leaf[next] = (i + 1 == steps);
        if (i + 1 == steps) node_sym[next] = sym;
        node = next;
      end
    end
  endtask

  task automatic walk_cipher_byte(input logic [BYTE_W-1:0] data);
    decoded_t batch [$];
    decoded_t r;
    int       next;
    for (int i = 0; i < BYTE_W; i++) begin
      next = node_kid[walk_node][data[i]];
      if (next == 0 || next >= NODE_DEPTH) begin
        r.symbol   = '0;
        r.bad_path = 1'b1;
        r.last     = 1'b0;
        batch      = {batch, r};
        walk_node = 0;
      end else if (node_leaf[next]) begin
        // drop symbols past the payload, but still go back to the root
        if (symbols_out < payload_len) begin
          r.symbol   = node_sym[next];
          r.bad_path = 1'b0;
          r.last     = 1'b0;
          batch      = {batch, r};
          symbols_out++;
        end
        walk_node = 0;
      end else begin
        walk_node = next;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    expected_symbols = {expected_symbols, batch};
  endtask

  task automatic check_result();
    decoded_t want;
    if (expected_symbols.size() == 0) begin
      report_mismatch($sformatf("unexpected beat: symbol %02h bad_path %0b last %0b",
                                out_tdata, out_tuser, out_tlast));
    end else begin
      want = expected_symbols.pop_front();
      if (out_tdata !== want.symbol)
        report_mismatch($sformatf("symbol %02h, expected %02h", out_tdata, want.symbol));
      if (out_tuser !== want.bad_path)
        report_mismatch($sformatf("bad_path %0b, expected %0b", out_tuser, want.bad_path));
      if (out_tlast !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", out_tlast, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_node(0);
      nodes_used  = 1;
      walk_node   = 0;
      symbols_out = '0;
      payload_len = '0;
      expected_symbols.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) payload_len = cfg_data;
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_CLEAR: begin
            wipe_node(0);
            nodes_used = 1;
            walk_node  = 0;
          end
          CMD_LOAD: begin
            grow_code_path(in_tdata[0 +: CODE_W], in_tdata[LEN_LO +: LEN_W],
                           in_tdata[SYM_LO +: SYM_W]);
          end
          CMD_DECODE: begin
            walk_cipher_byte(in_tdata[DATA_LO +: BYTE_W]);
          end
          CMD_START: begin
            walk_node   = 0;
            symbols_out = '0;
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_symbols.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the Huffman tree decoder testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hf_pkg::*;

  // Settle time before a config write and at the end. A load walks its code bit by bit,
  // and loads still sitting in the input queue run on after the last expected beat has
  // arrived, so allow plenty.
  localparam int DRAIN_CYCLES = 1500;
  // Cycles without any accepted beat before the run is declared hung. Must stay well above
  // DRAIN_CYCLES and above a full input queue of 32-bit loads plus the longest sink stall.
  localparam int QUIET_LIMIT  = 20000;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_TRICKLE} sink_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // code_bits[31:0], code_length[37:32], code_symbol[45:38], data_byte[53:46], zero pad
  logic [55:0]          in_tdata;
  // command[1:0]
  logic [CMD_W-1:0]     in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // symbol[7:0]
  logic [SYM_W-1:0]     out_tdata;
  // bad_path[0]
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PAYLOAD_W-1:0] cfg_data;

  int          pending;
  int          mismatches;
  int          burst_left;
  int          quiet_cycles;
  int          stall_span;
  sink_mode_t  sink_mode;
  logic [31:0] tree_bits [16];
  logic [5:0]  tree_len  [16];

  huffman_tree_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  huffman_decode_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sink side: switch between always ready, coin-flip ready and a sparse trickle that
  // raises ready only when the span count is a multiple of 16. Each mode lasts a random span.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      sink_mode  <= sink_mode_t'($urandom_range(0, 2));
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (sink_mode)
      SINK_OPEN: out_tready <= 1'b1;
      SINK_COIN: out_tready <= 1'($urandom_range(0, 1));
      default:   out_tready <= (stall_span % 16 == 0);
    endcase
  end

  // Watchdog: restart the count on any accepted beat, give up after too long a silence.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one command beat and hold it until accepted. The source runs in bursts: when a
  // burst is used up, drop valid for a random gap and pick a new burst length. A long
  // burst now and then gives stretches with no source idling at all.
  task automatic send_beat(input logic [CMD_W-1:0] kind, input logic [31:0] bits,
                           input logic [5:0] len, input logic [7:0] sym,
                           input logic [7:0] data);
    if (burst_left == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, data, sym, len, bits};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // Pause the source until every predicted beat has come out.
  task automatic hold_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // Make the block idle: drain expected beats, then let queued no-result work finish.
  task automatic drain_and_settle();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_payload(input logic [PAYLOAD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One message: clear the tree, load a random prefix-free code, start, then decode
  // random bytes mixed with the odd restart and the odd fully random beat.
  task automatic run_message(input int n_bytes);
    int          target;
    int          skip;
    int          k;
    logic [31:0] b;
    send_beat(CMD_CLEAR, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
    // Grow a full binary tree by splitting random leaves: split leaf k into k (bit 0)
    // and a new leaf (bit 1) one level deeper. Codes are consumed bit 0 first.
    target       = $urandom_range(2, 12);
    tree_bits[0] = '0;
    tree_len[0]  = '0;
    for (int n = 1; n < target; n++) begin
      k            = $urandom_range(0, n - 1);
      tree_bits[n] = tree_bits[k] | (32'd1 << tree_len[k]);
      tree_len[n]  = tree_len[k] + 6'd1;
      tree_len[k]  = tree_len[k] + 6'd1;
    end
    // Leave one code out now and then so that some paths lead nowhere.
    skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, target - 1) : -1;
    for (int n = 0; n < target; n++) begin
      if (n != skip) begin
        b = tree_bits[n];
        // junk above the code length must be ignored
        if ($urandom_range(0, 1) == 1) b = b | ($urandom << tree_len[n]);
        send_beat(CMD_LOAD, b, tree_len[n], 8'($urandom), 8'($urandom));
      end
    end
    send_beat(CMD_START, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
    for (int n = 0; n < n_bytes; n++) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        send_beat(CMD_START, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
      end else if (k == 1) begin
        send_beat(CMD_W'($urandom_range(0, 3)), $urandom, 6'($urandom), 8'($urandom),
                  8'($urandom));
      end else begin
        send_beat(CMD_DECODE, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) hold_until_drained();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_CLEAR;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    burst_left = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, payload still at its reset value of zero.
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'h00);         // empty tree: eight bad paths
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 6'd0, 8'hFF, 8'h00);   // zero length: skipped
    send_beat(CMD_LOAD, 32'h0, 6'd1, 8'hAA, 8'h00);
    send_beat(CMD_LOAD, 32'h1, 6'd1, 8'h55, 8'h00);
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'hFF);         // every symbol dropped
    drain_and_settle();
    write_payload(24'd4);
    send_beat(CMD_START, 32'h0, 6'd0, 8'h00, 8'h00);
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'hF0);         // payload reached mid-byte
    send_beat(CMD_START, 32'h0, 6'd0, 8'h00, 8'h00);
    // Over-long load saturates to 32 bits and turns the leaf for "1" into an inner node.
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 6'd63, 8'h00, 8'h00);
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'hFF);         // deep walk, no symbol yet
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'hFE);         // missing child mid-walk
    send_beat(CMD_CLEAR, 32'h0, 6'd0, 8'h00, 8'h00);          // emitted count is kept
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'h01);
    send_beat(CMD_LOAD, 32'h0, 6'd2, 8'h7E, 8'h00);
    send_beat(CMD_LOAD, 32'h1, 6'd1, 8'h00, 8'h00);
    send_beat(CMD_LOAD, 32'h0, 6'd1, 8'h81, 8'h00);           // inner node becomes a leaf
    send_beat(CMD_START, 32'h0, 6'd0, 8'h00, 8'h00);
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'hA5);
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'h5A);
    send_beat(CMD_LOAD, 32'h8000_0000, 6'd32, 8'hC3, 8'h00);  // full-length code
    send_beat(CMD_DECODE, 32'h0, 6'd0, 8'h00, 8'h3C);

    // Random part, one payload setting per phase.
    drain_and_settle();
    write_payload(24'hFF_FFFF);
    run_message(8);
    drain_and_settle();
    write_payload(24'd1);
    run_message(8);
    drain_and_settle();
    write_payload(PAYLOAD_W'($urandom_range(2, 30)));
    run_message(8);

    // Fill the node table with long random codes until loads get cut short.
    drain_and_settle();
    write_payload(PAYLOAD_W'($urandom));
    send_beat(CMD_CLEAR, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
    repeat (20) send_beat(CMD_LOAD, $urandom, 6'd32, 8'($urandom), 8'($urandom));
    send_beat(CMD_LOAD, $urandom, 6'($urandom_range(33, 63)), 8'($urandom), 8'($urandom));
    send_beat(CMD_START, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));
    repeat (6) send_beat(CMD_DECODE, $urandom, 6'($urandom), 8'($urandom), 8'($urandom));

    drain_and_settle();
    write_payload(24'd0);
    run_message(4);
    drain_and_settle();
    write_payload(24'hFF_FFFF);
    run_message(8);

    // Wind down: wait for the last beats, then watch for stray ones.
    drain_and_settle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
